@@ hdl/bidcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidcc_pkg
// Shared widths, command and register codes, and the table write item
// broadcast to the bond cells of the block index decoder.
// ----------------------------------------------------------------------------
package bidcc_pkg;

  // Field widths of the ports
  localparam int CMD_W      = 2;
  localparam int BOND_FW    = 3;
  localparam int SECTOR_FW  = 4;
  localparam int CHARGE_FW  = 8;
  localparam int DIM_FW     = 16;
  localparam int COUNT_FW   = 5;
  localparam int IDX_W      = 32;
  localparam int NUMB_FW    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SECTOR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEADER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BONDS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_CHARGE = 1'd1;

  // Divider: quotient bits resolved per cycle in each cell
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = IDX_W / DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_CYCLES);

  // Table write item, broadcast to every cell
  typedef struct packed {
    logic                        sec_en;
    logic                        hdr_en;
    logic [BOND_FW-1:0]          bond;
    logic [SECTOR_FW-1:0]        sector;
    logic signed [CHARGE_FW-1:0] charge;
    logic [DIM_FW-1:0]           dim;
    logic                        direction;
    logic [COUNT_FW-1:0]         count;
  } wr_t;

endpackage

@@ hdl/bidcc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidcc_cell
// One bond of the decoder: holds the bond's sector table, count and
// direction, peels one mixed-radix digit off the incoming index, adds or
// subtracts the selected charge in the running sum for the next bond.
// ----------------------------------------------------------------------------
module bidcc_cell #(
  parameter int IDX         = 0,
  parameter int MAX_SECTORS = 16,
  parameter int DIM_BITS    = 16,
  parameter int CHARGE_BITS = 8,
  parameter int SUM_W       = 12,
  parameter int NB_W        = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bidcc_pkg::wr_t                    wr_i,
  input  logic [NB_W-1:0]                   nb_i,
  input  logic                              tok_valid_i,
  input  logic [bidcc_pkg::IDX_W-1:0]       tok_rest_i,
  input  logic signed [SUM_W-1:0]           tok_sum_i,
  output logic                              fwd_valid_o,
  output logic [bidcc_pkg::IDX_W-1:0]       fwd_rest_o,
  output logic signed [SUM_W-1:0]           fwd_sum_o,
  output logic                              fin_o,
  output logic signed [CHARGE_BITS-1:0]     sel_charge_o,
  output logic [DIM_BITS-1:0]               sel_dim_o
);
  import bidcc_pkg::*;

  localparam int SEC_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTORS + 1);

  // Bond state
  logic signed [CHARGE_BITS-1:0] charge_q [MAX_SECTORS];
  logic [DIM_BITS-1:0]           dim_q    [MAX_SECTORS];
  logic [CNT_W-1:0]              count_q;
  logic                          dir_q;

  // Divider state
  logic                    busy_q;
  logic [STEP_W-1:0]       step_q;
  logic [IDX_W-1:0]        quo_q, quo_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic signed [SUM_W-1:0] sum_in_q;

  logic                    fwd_valid_q, fin_q;
  logic [IDX_W-1:0]        fwd_rest_q;
  logic signed [SUM_W-1:0] fwd_sum_q, sum_nx;
  logic signed [CHARGE_BITS-1:0] sel_charge_q;
  logic [DIM_BITS-1:0]     sel_dim_q;

  logic                    bond_hit, sec_ok, cnt_ok, is_last;
  logic [31:0]             sec32, cnt32, dim32;
  logic signed [31:0]      chg32;
  logic [SEC_W-1:0]        sel_idx;
  logic signed [SUM_W-1:0] sel_x;
  logic                    div_done;

  // Write decode
  always_comb begin
    sec32    = 32'(wr_i.sector);
    cnt32    = 32'(wr_i.count);
    dim32    = 32'(wr_i.dim);
    chg32    = 32'(wr_i.charge);
    bond_hit = (32'(wr_i.bond) == 32'(IDX));
    sec_ok   = (sec32 < 32'(MAX_SECTORS));
    cnt_ok   = (cnt32 >= 32'd1) && (cnt32 <= 32'(MAX_SECTORS));
    is_last  = (32'(IDX) + 32'd1 == 32'(nb_i));
  end

  // Sector table and header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAX_SECTORS; s++) begin
        charge_q[s] <= '0;
        dim_q[s]    <= '0;
      end
      count_q <= CNT_W'(1);
      dir_q   <= 1'b0;
    end else begin
      if (wr_i.sec_en && bond_hit && sec_ok) begin
        charge_q[sec32[SEC_W-1:0]] <= chg32[CHARGE_BITS-1:0];
        dim_q[sec32[SEC_W-1:0]]    <= dim32[DIM_BITS-1:0];
      end
      if (wr_i.hdr_en && bond_hit && cnt_ok) begin
        count_q <= cnt32[CNT_W-1:0];
        dir_q   <= wr_i.direction;
      end
    end
  end

  // Restoring division by the sector count, DIV_BITS quotient bits a cycle
  always_comb begin
    logic [IDX_W-1:0] q;
    logic [CNT_W:0]   r;
    q = quo_q;
    r = {1'b0, rem_q};
    for (int k = 0; k < DIV_BITS; k++) begin
      r = {r[CNT_W-1:0], q[IDX_W-1]};
      q = {q[IDX_W-2:0], 1'b0};
      if (r >= {1'b0, count_q}) begin
        r    = r - {1'b0, count_q};
        q[0] = 1'b1;
      end
    end
    quo_d = q;
    rem_d = r[CNT_W-1:0];
  end

  // Sector pick and charge accumulation on the final division cycle
  always_comb begin
    sel_idx = rem_d[SEC_W-1:0];
    sel_x   = SUM_W'(charge_q[sel_idx]);
    sum_nx  = dir_q ? (sum_in_q - sel_x) : (sum_in_q + sel_x);
  end

  assign div_done = busy_q && !tok_valid_i && (step_q == STEP_W'(DIV_CYCLES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      fwd_valid_q <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      fwd_valid_q <= div_done && !is_last;
      fin_q       <= div_done && is_last;
      if (tok_valid_i) begin
        busy_q   <= 1'b1;
        step_q   <= '0;
        quo_q    <= tok_rest_i;
        rem_q    <= '0;
        sum_in_q <= tok_sum_i;
      end else if (busy_q) begin
        quo_q  <= quo_d;
        rem_q  <= rem_d;
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIV_CYCLES - 1)) begin
          busy_q       <= 1'b0;
          fwd_rest_q   <= quo_d;
          fwd_sum_q    <= sum_nx;
          sel_charge_q <= charge_q[sel_idx];
          sel_dim_q    <= dim_q[sel_idx];
        end
      end
    end
  end

  assign fwd_valid_o  = fwd_valid_q;
  assign fwd_rest_o   = fwd_rest_q;
  assign fwd_sum_o    = fwd_sum_q;
  assign fin_o        = fin_q;
  assign sel_charge_o = sel_charge_q;
  assign sel_dim_o    = sel_dim_q;

endmodule

@@ hdl/block_index_decode_charge_check_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_index_decode_charge_check_top
// U1 block-sparse index decoder: splits a flat block index into per-bond
// sectors and checks the net charge of the block.
// ----------------------------------------------------------------------------
// Write items (sector entry, bond header) are broadcast to the cells as they
// are taken. A decode item runs through a chain of bond cells, one per bond in
// use; each cell divides the remaining index by its sector count at four
// quotient bits per cycle before handing on. The results are then emitted one
// per cycle while the output is not stalled. The range check falls out of the
// chain: the index is out of range exactly when the quotient left after the
// last bond is nonzero, and then a single error result is given instead. Input
// is stalled while a decode is in flight; the last result may still wait in
// the output register while the next item is taken.
// ----------------------------------------------------------------------------
module block_index_decode_charge_check_top #(
  parameter int MAX_BONDS   = 8,
  parameter int MAX_SECTORS = 16,
  parameter int DIM_BITS    = 16,
  parameter int CHARGE_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [bidcc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bidcc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input items
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [bidcc_pkg::CMD_W-1:0]            cmd_i,
  input  logic [bidcc_pkg::BOND_FW-1:0]          bond_i,
  input  logic [bidcc_pkg::SECTOR_FW-1:0]        sector_i,
  input  logic signed [bidcc_pkg::CHARGE_FW-1:0] charge_i,
  input  logic [bidcc_pkg::DIM_FW-1:0]           dim_i,
  input  logic                                   direction_i,
  input  logic [bidcc_pkg::COUNT_FW-1:0]         count_i,
  input  logic [bidcc_pkg::IDX_W-1:0]            block_index_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [bidcc_pkg::BOND_FW-1:0]          out_bond_o,
  output logic signed [bidcc_pkg::CHARGE_FW-1:0] out_charge_o,
  output logic [bidcc_pkg::DIM_FW-1:0]           out_dim_o,
  output logic                                   allowed_o,
  output logic                                   error_o,
  output logic                                   last_o
);
  import bidcc_pkg::*;

  localparam int BOND_W = $clog2(MAX_BONDS);
  localparam int NB_W   = $clog2(MAX_BONDS + 1);
  localparam int RAW_W  = CHARGE_BITS + $clog2(MAX_BONDS) + 1;
  localparam int SUM_W  = (RAW_W > CHARGE_FW) ? RAW_W : CHARGE_FW;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} state_e;

  // Configuration registers
  logic [NUMB_FW-1:0]          num_bonds_q;
  logic signed [CHARGE_FW-1:0] net_charge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bonds_q  <= NUMB_FW'(1);
      net_charge_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_BONDS:  num_bonds_q  <= cfg_data_i[NUMB_FW-1:0];
        CFG_NET_CHARGE: net_charge_q <= cfg_data_i[CHARGE_FW-1:0];
      endcase
    end
  end

  // Bonds in use, clamped to 1..MAX_BONDS
  logic [31:0]       nb32, lb32;
  logic [NB_W-1:0]   nb_eff;
  logic [BOND_W-1:0] lb;

  always_comb begin
    nb32 = 32'(num_bonds_q);
    if (nb32 < 32'd1) begin
      nb32 = 32'd1;
    end else if (nb32 > 32'(MAX_BONDS)) begin
      nb32 = 32'(MAX_BONDS);
    end
    nb_eff = nb32[NB_W-1:0];
    lb32   = nb32 - 32'd1;
    lb     = lb32[BOND_W-1:0];
  end

  // Input handshake and write broadcast
  state_e state_q;
  logic   in_acc;
  wr_t    wr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    wr.sec_en    = in_acc && (cmd_i == CMD_SECTOR);
    wr.hdr_en    = in_acc && (cmd_i == CMD_HEADER);
    wr.bond      = bond_i;
    wr.sector    = sector_i;
    wr.charge    = charge_i;
    wr.dim       = dim_i;
    wr.direction = direction_i;
    wr.count     = count_i;
  end

  // Chain of bond cells
  logic                          start_q;
  logic [IDX_W-1:0]              rest_q;
  logic                          tok_valid [MAX_BONDS];
  logic [IDX_W-1:0]              tok_rest  [MAX_BONDS];
  logic signed [SUM_W-1:0]       tok_sum   [MAX_BONDS];
  logic                          fwd_valid [MAX_BONDS];
  logic [IDX_W-1:0]              fwd_rest  [MAX_BONDS];
  logic signed [SUM_W-1:0]       fwd_sum   [MAX_BONDS];
  logic [MAX_BONDS-1:0]          fin;
  logic signed [CHARGE_BITS-1:0] sel_charge [MAX_BONDS];
  logic [DIM_BITS-1:0]           sel_dim    [MAX_BONDS];

  for (genvar b = 0; b < MAX_BONDS; b++) begin : g_cell
    if (b == 0) begin : g_head
      assign tok_valid[b] = start_q;
      assign tok_rest[b]  = rest_q;
      assign tok_sum[b]   = '0;
    end else begin : g_link
      assign tok_valid[b] = fwd_valid[b-1];
      assign tok_rest[b]  = fwd_rest[b-1];
      assign tok_sum[b]   = fwd_sum[b-1];
    end

    bidcc_cell #(
      .IDX         (b),
      .MAX_SECTORS (MAX_SECTORS),
      .DIM_BITS    (DIM_BITS),
      .CHARGE_BITS (CHARGE_BITS),
      .SUM_W       (SUM_W),
      .NB_W        (NB_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_i         (wr),
      .nb_i         (nb_eff),
      .tok_valid_i  (tok_valid[b]),
      .tok_rest_i   (tok_rest[b]),
      .tok_sum_i    (tok_sum[b]),
      .fwd_valid_o  (fwd_valid[b]),
      .fwd_rest_o   (fwd_rest[b]),
      .fwd_sum_o    (fwd_sum[b]),
      .fin_o        (fin[b]),
      .sel_charge_o (sel_charge[b]),
      .sel_dim_o    (sel_dim[b])
    );
  end

  // Result formatting for the bond being emitted
  logic                    err_q, ok_q;
  logic [BOND_W-1:0]       e_q;
  logic signed [SUM_W-1:0] net_x;
  logic                    e_last;
  logic [31:0]             e32, dim32;
  logic signed [31:0]      chg32;

  always_comb begin
    net_x  = SUM_W'(net_charge_q);
    e_last = (e_q == lb);
    e32    = 32'(e_q);
    chg32  = 32'(sel_charge[e_q]);
    dim32  = 32'(sel_dim[e_q]);
  end

  // Sequencer with output register
  logic                        out_valid_q, allowed_q, error_q, last_q;
  logic [BOND_FW-1:0]          out_bond_q;
  logic signed [CHARGE_FW-1:0] out_charge_q;
  logic [DIM_FW-1:0]           out_dim_q;
  logic                        out_free;
  logic                        emit_go;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_go  = (state_q == S_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      e_q         <= '0;
    end else begin
      start_q <= in_acc && (cmd_i == CMD_DECODE);
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (cmd_i == CMD_DECODE)) begin
            rest_q  <= block_index_i;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (|fin) begin
            err_q   <= (fwd_rest[lb] != '0);
            ok_q    <= (fwd_sum[lb] == net_x);
            e_q     <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (err_q) begin
              out_bond_q   <= '0;
              out_charge_q <= '0;
              out_dim_q    <= '0;
              allowed_q    <= 1'b0;
              error_q      <= 1'b1;
              last_q       <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              out_bond_q   <= e32[BOND_FW-1:0];
              out_charge_q <= chg32[CHARGE_FW-1:0];
              out_dim_q    <= dim32[DIM_FW-1:0];
              allowed_q    <= e_last && ok_q;
              error_q      <= 1'b0;
              last_q       <= e_last;
              if (e_last) begin
                state_q <= S_IDLE;
              end else begin
                e_q <= e_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_bond_o   = out_bond_q;
  assign out_charge_o = out_charge_q;
  assign out_dim_o    = out_dim_q;
  assign allowed_o    = allowed_q;
  assign error_o      = error_q;
  assign last_o       = last_q;

endmodule
